// ===== sv/slot_allocator_lru_pinned_top_assert.svh =====
// assertion macros for the slot allocator
// used by slot_allocator_lru_pinned_top, expects clk_i and rst_ni in scope
`ifndef SLOT_ALLOCATOR_LRU_PINNED_TOP_ASSERT_SVH
`define SLOT_ALLOCATOR_LRU_PINNED_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SLAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SLAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLAL_ASSERT_IMP(lbl, ante, cons, msg)
`define SLAL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/slal_pkg.sv =====
// shared types, codes and constants of the slot allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slal_pkg;
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ID_W   = 64;

  typedef enum logic [1:0] {
    OP_ACQUIRE   = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_END_ROUND = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALL_PINNED = 2'd1,
    ST_UNMAPPED   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_POP,
    S_WALK,
    S_PUSH,
    S_DONE
  } state_e;

  // out-of-range slot counts fold into 1..SLOTS
  function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(SLOTS)) r = CNT_W'(SLOTS);
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/slot_allocator_lru_pinned_top.sv =====
// top level of the lru slot allocator with per-round pinning
// depends on slal_pkg, slal_ram, slal_free_stack and the assertion header
//
//  channel | signals                                   | dir
//  in      | in_valid_i, in_stall_o, operation_i, context_id_i | in
//  out     | out_valid_o, out_stall_i, slot_index_o, fresh_o, status_o | out
//  cfg     | cfg_we_i, cfg_wdata_i                     | in
//
// one item at a time: a scan of up to active_slots tags, then a walk of the
// recency memory of up to recency_count entries or a pop of the free stack,
// then the update and the result register.
// end of round and the unused code go straight to the result register.
// a new item is taken while the previous result waits in the output register.
// reset and a slot count write clear valid and pin flops at once; no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "slot_allocator_lru_pinned_top_assert.svh"
module slot_allocator_lru_pinned_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  operation_i,
  input  wire logic [slal_pkg::ID_W-1:0]   context_id_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [slal_pkg::SLOT_W-1:0] slot_index_o,
  output logic                             fresh_o,
  output logic      [1:0]                  status_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [slal_pkg::CNT_W-1:0]  cfg_wdata_i
);
  import slal_pkg::*;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  status_e           status_q, status_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              found_q, found_d;
  logic              fresh_q, fresh_d;
  logic              evict_q, evict_d;
  logic [CNT_W-1:0]  active_q, active_d;
  logic [CNT_W-1:0]  rec_count_q, rec_count_d;
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SLOTS-1:0]  pinned_q, pinned_d;
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_fresh_q, out_fresh_d;
  status_e           out_status_q, out_status_d;

  logic              tag_we;
  logic [SLOT_W-1:0] tag_raddr;
  logic [ID_W-1:0]   tag_rdata;
  logic              rec_we;
  logic [SLOT_W-1:0] rec_waddr, rec_wdata, rec_raddr, rec_rdata;
  logic              fs_we, fs_clear;
  logic [SLOT_W-1:0] fs_waddr, fs_raddr, fs_rdata;
  logic              hit_now, match, last;

  // context tags
  slal_ram #(.W(ID_W), .D(SLOTS)) u_tag_mem (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (slot_q),
    .wdata_i (id_q),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // recency order, oldest at position 0
  slal_ram #(.W(SLOT_W), .D(SLOTS)) u_rec_mem (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  // free slot stack
  slal_free_stack u_free_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (fs_clear),
    .active_i (active_q),
    .we_i     (fs_we),
    .waddr_i  (fs_waddr),
    .wdata_i  (slot_q),
    .raddr_i  (fs_raddr),
    .rdata_o  (fs_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign hit_now    = valid_q[idx_q] && (tag_rdata == id_q);
  assign match      = evict_q ? !pinned_q[rec_rdata] : (rec_rdata == slot_q);
  assign last       = ({1'b0, idx_q} == rec_count_q - CNT_W'(1));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= CNT_W'(SLOTS);
      rec_count_q  <= '0;
      free_count_q <= CNT_W'(SLOTS);
      valid_q      <= '0;
      pinned_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      rec_count_q  <= rec_count_d;
      free_count_q <= free_count_d;
      valid_q      <= valid_d;
      pinned_q     <= pinned_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // item payload and result registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    id_q         <= id_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    found_q      <= found_d;
    fresh_q      <= fresh_d;
    evict_q      <= evict_d;
    out_slot_q   <= out_slot_d;
    out_fresh_q  <= out_fresh_d;
    out_status_q <= out_status_d;
  end

  // sequencer: scan tags, walk recency list or pop free stack, update, deliver
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    id_d         = id_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    found_d      = found_q;
    fresh_d      = fresh_q;
    evict_d      = evict_q;
    active_d     = active_q;
    rec_count_d  = rec_count_q;
    free_count_d = free_count_q;
    valid_d      = valid_q;
    pinned_d     = pinned_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_slot_d   = out_slot_q;
    out_fresh_d  = out_fresh_q;
    out_status_d = out_status_q;
    tag_we       = 1'b0;
    tag_raddr    = idx_q + SLOT_W'(1);
    rec_we       = 1'b0;
    rec_waddr    = idx_q - SLOT_W'(1);
    rec_wdata    = rec_rdata;
    rec_raddr    = idx_q + SLOT_W'(1);
    fs_we        = 1'b0;
    fs_clear     = 1'b0;
    fs_waddr     = free_count_q[SLOT_W-1:0];
    fs_raddr     = free_count_q[SLOT_W-1:0] - SLOT_W'(1);

    unique case (state_q)
      S_IDLE: begin
        tag_raddr = '0;
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          id_d     = context_id_i;
          status_d = ST_OK;
          slot_d   = '0;
          idx_d    = '0;
          found_d  = 1'b0;
          fresh_d  = 1'b0;
          evict_d  = 1'b0;
          unique case (op_e'(operation_i)) inside
            OP_ACQUIRE, OP_RELEASE: state_d = S_LOOK;
            OP_END_ROUND: begin
              pinned_d = '0;
              state_d  = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // lowest matching valid slot wins
      S_LOOK: begin
        if (hit_now) begin
          slot_d    = idx_q;
          idx_d     = '0;
          rec_raddr = '0;
          state_d   = S_WALK;
        end else if ({1'b0, idx_q} == active_q - CNT_W'(1)) begin
          if (op_q == OP_RELEASE) begin
            status_d = ST_UNMAPPED;
            state_d  = S_DONE;
          end else if (free_count_q != '0) begin
            state_d = S_POP;
          end else if (rec_count_q == '0) begin
            status_d = ST_ALL_PINNED;
            state_d  = S_DONE;
          end else begin
            evict_d   = 1'b1;
            idx_d     = '0;
            rec_raddr = '0;
            state_d   = S_WALK;
          end
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      S_POP: begin
        slot_d       = fs_rdata;
        free_count_d = free_count_q - CNT_W'(1);
        fresh_d      = 1'b1;
        state_d      = S_PUSH;
      end

      // remove one entry, shifting the younger ones down by one
      S_WALK: begin
        if (found_q) rec_we = 1'b1;
        if (!found_q && match) begin
          found_d = 1'b1;
          if (evict_q) slot_d = rec_rdata;
        end
        if (last) begin
          if (found_q || match) begin
            rec_count_d = rec_count_q - CNT_W'(1);
            fresh_d     = evict_q;
            state_d     = S_PUSH;
          end else begin
            status_d = ST_ALL_PINNED;
            state_d  = S_DONE;
          end
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end

      S_PUSH: begin
        if (op_q == OP_ACQUIRE) begin
          tag_we           = 1'b1;
          valid_d[slot_q]  = 1'b1;
          pinned_d[slot_q] = 1'b1;
          if (rec_count_q < CNT_W'(SLOTS)) begin
            rec_we      = 1'b1;
            rec_waddr   = rec_count_q[SLOT_W-1:0];
            rec_wdata   = slot_q;
            rec_count_d = rec_count_q + CNT_W'(1);
          end
        end else begin
          valid_d[slot_q] = 1'b0;
          if (free_count_q < CNT_W'(SLOTS)) begin
            fs_we        = 1'b1;
            free_count_d = free_count_q + CNT_W'(1);
          end
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_slot_d   = (op_q == OP_ACQUIRE && status_q == ST_OK) ? slot_q : '0;
          out_fresh_d  = fresh_q;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // slot count write reinitializes the allocator
    if (cfg_we_i) begin
      active_d     = clamp_slots(cfg_wdata_i);
      free_count_d = clamp_slots(cfg_wdata_i);
      rec_count_d  = '0;
      valid_d      = '0;
      pinned_d     = '0;
      fs_clear     = 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_index_o = out_slot_q;
  assign fresh_o      = out_fresh_q;
  assign status_o     = out_status_q;

  // checks
  `SLAL_ASSERT_IMP(a_rec_bound, 1'b1, rec_count_q <= active_q, "recency list exceeds slots")
  `SLAL_ASSERT_IMP(a_fresh_ok, out_valid_o && fresh_o, status_o == ST_OK, "fresh with error")
  `SLAL_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy")
endmodule
`default_nettype wire

// ===== sv/slal_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module slal_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/slal_free_stack.sv =====
// free slot stack memory; unwritten entries read as the descending reset fill
// depends on slal_pkg
`timescale 1ns / 1ps
`default_nettype none
module slal_free_stack (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        clear_i,
  input  wire logic [slal_pkg::CNT_W-1:0]  active_i,
  input  wire logic                        we_i,
  input  wire logic [slal_pkg::SLOT_W-1:0] waddr_i,
  input  wire logic [slal_pkg::SLOT_W-1:0] wdata_i,
  input  wire logic [slal_pkg::SLOT_W-1:0] raddr_i,
  output logic      [slal_pkg::SLOT_W-1:0] rdata_o
);
  import slal_pkg::*;

  logic [SLOT_W-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]  written_q;
  logic [SLOT_W-1:0] rd_data_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_written_q;
  logic [CNT_W-1:0]  fill_val;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rd_data_q <= mem_q[raddr_i];
    rd_idx_q  <= raddr_i;
  end

  // per-entry written marks, cleared on reinit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      rd_written_q <= written_q[raddr_i];
      if (clear_i) written_q <= '0;
      else if (we_i) written_q[waddr_i] <= 1'b1;
    end
  end

  // reset fill: entry e holds active-1-e
  assign fill_val = active_i - CNT_W'(1) - {1'b0, rd_idx_q};
  assign rdata_o  = rd_written_q ? rd_data_q : fill_val[SLOT_W-1:0];
endmodule
`default_nettype wire
